@@ hdl/list_diff_engine_defines.svh @@
// Assertion macros used by the checker file of the list diff engine.
`ifndef LIST_DIFF_ENGINE_DEFINES_SVH
`define LIST_DIFF_ENGINE_DEFINES_SVH

// When the antecedent holds, the consequent holds in the same cycle.
`define LDE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("list diff engine check failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define LDE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("list diff engine check failed");

`endif

@@ hdl/ldiff_pkg.sv @@
// Package with the types and constants of the list diff engine.
`timescale 1ns / 1ps
`default_nettype none
package ldiff_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int KEY_W     = 64;

  typedef enum logic [1:0] {
    OP_LOAD_OLD = 2'd0,
    OP_LOAD_NEW = 2'd1,
    OP_COMPUTE  = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_DELETE = 3'd0,
    K_INSERT = 3'd1,
    K_UPDATE = 3'd2,
    K_MOVE   = 3'd3,
    K_END    = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PR_INIT,
    S_PR_SCAN,
    S_PR_CONT,
    S_CH_INIT,
    S_CH_SCAN,
    S_DEL,
    S_NEW,
    S_MOVE,
    S_END
  } state_t;

  // Write request from the sequencer to the list store.
  typedef struct packed {
    logic             we_old;
    logic             we_new;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] ident;
    logic [KEY_W-1:0] content;
  } wr_t;

  // Read addresses from the sequencer to the list store.
  typedef struct packed {
    logic [IDX_W-1:0] nid_addr;
    logic [IDX_W-1:0] nc_addr;
    logic [IDX_W-1:0] oid_addr;
    logic [IDX_W-1:0] oc_addr;
  } rd_t;

endpackage
`default_nettype wire

@@ hdl/ldiff_if.sv @@
// Interfaces of the input and result channels of the list diff engine.
`timescale 1ns / 1ps
`default_nettype none
interface ldiff_in_if;
  import ldiff_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [KEY_W-1:0] item_key;
  logic [KEY_W-1:0] contents_key;
  modport source (output valid, output op, output item_key, output contents_key,
                  input ready);
  modport sink (input valid, input op, input item_key, input contents_key,
                output ready);
endinterface

interface ldiff_out_if;
  import ldiff_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [IDX_W-1:0] old_index;
  logic [IDX_W-1:0] new_index;
  logic             overflow;
  logic             last;
  modport source (output valid, output kind, output old_index, output new_index,
                  output overflow, output last, input ready);
  modport sink (input valid, input kind, input old_index, input new_index,
                input overflow, input last, output ready);
endinterface
`default_nettype wire

@@ hdl/ldiff_store.sv @@
// Register store holding the identity and contents keys of both lists.
`timescale 1ns / 1ps
`default_nettype none
module ldiff_store (
  input  wire               clk,
  input  ldiff_pkg::wr_t    wr,
  input  ldiff_pkg::rd_t    rd,
  output logic [63:0]       nid_q,
  output logic [63:0]       nc_q,
  output logic [63:0]       oid_q,
  output logic [63:0]       oc_q
);
  import ldiff_pkg::*;

  logic [KEY_W-1:0] old_ident_r   [MAX_ITEMS];
  logic [KEY_W-1:0] old_content_r [MAX_ITEMS];
  logic [KEY_W-1:0] new_ident_r   [MAX_ITEMS];
  logic [KEY_W-1:0] new_content_r [MAX_ITEMS];

  // Loads write one word into the list that the operation names.
  always_ff @(posedge clk) begin
    if (wr.we_old) begin
      old_ident_r[wr.waddr]   <= wr.ident;
      old_content_r[wr.waddr] <= wr.content;
    end
    if (wr.we_new) begin
      new_ident_r[wr.waddr]   <= wr.ident;
      new_content_r[wr.waddr] <= wr.content;
    end
  end

  // Each list array is read at one address per cycle.
  assign nid_q = new_ident_r[rd.nid_addr];
  assign nc_q  = new_content_r[rd.nc_addr];
  assign oid_q = old_ident_r[rd.oid_addr];
  assign oc_q  = old_content_r[rd.oc_addr];

endmodule
`default_nettype wire

@@ hdl/ldiff_seq.sv @@
// Sequencer that pairs, marks and emits the diff through one shared comparator.
`timescale 1ns / 1ps
`default_nettype none
module ldiff_seq (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [1:0]        in_op,
  input  wire  [63:0]       in_item_key,
  input  wire  [63:0]       in_contents_key,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [2:0]        out_kind,
  output logic [3:0]        out_old_index,
  output logic [3:0]        out_new_index,
  output logic              out_overflow,
  output logic              out_last,
  output ldiff_pkg::wr_t    wr,
  output ldiff_pkg::rd_t    rd,
  input  wire  [63:0]       nid_q,
  input  wire  [63:0]       nc_q,
  input  wire  [63:0]       oid_q,
  input  wire  [63:0]       oc_q
);
  import ldiff_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] old_fill_r, old_fill_nxt;
  logic [CNT_W-1:0] new_fill_r, new_fill_nxt;
  logic             dropped_r, dropped_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] o_r, o_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] del_r, del_nxt;
  logic [CNT_W-1:0] ins_r, ins_nxt;
  logic [KEY_W-1:0] key_a_r, key_a_nxt;

  logic [MAX_ITEMS-1:0] old_paired_r, old_paired_nxt;
  logic [MAX_ITEMS-1:0] new_paired_r, new_paired_nxt;
  logic [MAX_ITEMS-1:0] diff_r, diff_nxt;
  logic [MAX_ITEMS-1:0] chg_r, chg_nxt;
  logic [IDX_W-1:0]     part_r   [MAX_ITEMS];
  logic [IDX_W-1:0]     part_nxt [MAX_ITEMS];
  logic [CNT_W-1:0]     doff_r   [MAX_ITEMS];
  logic [CNT_W-1:0]     doff_nxt [MAX_ITEMS];

  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0] out_oi_r, out_oi_nxt;
  logic [IDX_W-1:0] out_ni_r, out_ni_nxt;
  logic             out_ovf_r, out_ovf_nxt;
  logic             out_last_r, out_last_nxt;

  logic [KEY_W-1:0] cmp_a, cmp_b;
  logic             cmp_eq;
  logic             out_free;
  logic [IDX_W-1:0] i_idx, o_idx, k_idx, p_idx;
  logic [CNT_W:0]   move_pos;

  assign i_idx = i_r[IDX_W-1:0];
  assign o_idx = o_r[IDX_W-1:0];
  assign k_idx = k_r[IDX_W-1:0];
  assign p_idx = part_r[i_idx];

  // Expected position of a paired item after the running offsets.
  assign move_pos = {2'b00, p_idx} - {1'b0, doff_r[p_idx]} + {1'b0, ins_r};

  // Store read addresses.
  always_comb begin
    rd.nid_addr = (state_r == S_CH_SCAN) ? k_idx : i_idx;
    rd.nc_addr  = i_idx;
    rd.oid_addr = o_idx;
    rd.oc_addr  = o_idx;
  end

  // The shared 64-bit equality comparator and its operand selection.
  always_comb begin
    case (state_r)
      S_PR_SCAN: begin
        cmp_a = nid_q;
        cmp_b = oid_q;
      end
      S_PR_CONT: begin
        cmp_a = nc_q;
        cmp_b = oc_q;
      end
      default: begin
        cmp_a = key_a_r;
        cmp_b = nid_q;
      end
    endcase
  end
  assign cmp_eq = (cmp_a == cmp_b);

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath updates.
  always_comb begin
    state_nxt      = state_r;
    old_fill_nxt   = old_fill_r;
    new_fill_nxt   = new_fill_r;
    dropped_nxt    = dropped_r;
    i_nxt          = i_r;
    o_nxt          = o_r;
    k_nxt          = k_r;
    del_nxt        = del_r;
    ins_nxt        = ins_r;
    key_a_nxt      = key_a_r;
    old_paired_nxt = old_paired_r;
    new_paired_nxt = new_paired_r;
    diff_nxt       = diff_r;
    chg_nxt        = chg_r;
    part_nxt       = part_r;
    doff_nxt       = doff_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_oi_nxt     = out_oi_r;
    out_ni_nxt     = out_ni_r;
    out_ovf_nxt    = out_ovf_r;
    out_last_nxt   = out_last_r;
    wr.we_old      = 1'b0;
    wr.we_new      = 1'b0;
    wr.waddr       = '0;
    wr.ident       = in_item_key;
    wr.content     = in_contents_key;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_LOAD_OLD: begin
              if (old_fill_r < CNT_W'(MAX_ITEMS)) begin
                wr.we_old    = 1'b1;
                wr.waddr     = old_fill_r[IDX_W-1:0];
                old_fill_nxt = old_fill_r + 1'b1;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            OP_LOAD_NEW: begin
              if (new_fill_r < CNT_W'(MAX_ITEMS)) begin
                wr.we_new    = 1'b1;
                wr.waddr     = new_fill_r[IDX_W-1:0];
                new_fill_nxt = new_fill_r + 1'b1;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            OP_COMPUTE: begin
              old_paired_nxt = '0;
              new_paired_nxt = '0;
              diff_nxt       = '0;
              i_nxt          = '0;
              state_nxt      = S_PR_INIT;
            end
            default: begin
            end
          endcase
        end
      end
      // Pair the new item with the first unpaired old item of equal identity.
      S_PR_INIT: begin
        if (i_r == new_fill_r) begin
          i_nxt     = '0;
          state_nxt = S_CH_INIT;
        end else begin
          o_nxt     = '0;
          state_nxt = S_PR_SCAN;
        end
      end
      S_PR_SCAN: begin
        if (o_r == old_fill_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_PR_INIT;
        end else if (cmp_eq && !old_paired_r[o_idx]) begin
          old_paired_nxt[o_idx] = 1'b1;
          new_paired_nxt[i_idx] = 1'b1;
          part_nxt[i_idx]       = o_idx;
          state_nxt             = S_PR_CONT;
        end else begin
          o_nxt = o_r + 1'b1;
        end
      end
      // Note whether the contents of the pair differ.
      S_PR_CONT: begin
        diff_nxt[i_idx] = !cmp_eq;
        i_nxt           = i_r + 1'b1;
        state_nxt       = S_PR_INIT;
      end
      // Mark a new item when any paired item of its identity changed.
      S_CH_INIT: begin
        if (i_r == new_fill_r) begin
          o_nxt     = '0;
          del_nxt   = '0;
          state_nxt = S_DEL;
        end else begin
          key_a_nxt      = nid_q;
          k_nxt          = '0;
          chg_nxt[i_idx] = 1'b0;
          state_nxt      = S_CH_SCAN;
        end
      end
      S_CH_SCAN: begin
        if (k_r == new_fill_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_CH_INIT;
        end else begin
          if (cmp_eq && diff_r[k_idx]) begin
            chg_nxt[i_idx] = 1'b1;
          end
          k_nxt = k_r + 1'b1;
        end
      end
      // Deletes for unpaired old items, with the running delete offset.
      S_DEL: begin
        if (o_r == old_fill_r) begin
          i_nxt     = '0;
          ins_nxt   = '0;
          state_nxt = S_NEW;
        end else begin
          doff_nxt[o_idx] = del_r;
          if (old_paired_r[o_idx]) begin
            o_nxt = o_r + 1'b1;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = K_DELETE;
            out_oi_nxt    = o_idx;
            out_ni_nxt    = '0;
            out_ovf_nxt   = 1'b0;
            out_last_nxt  = 1'b0;
            del_nxt       = del_r + 1'b1;
            o_nxt         = o_r + 1'b1;
          end
        end
      end
      // Insert for an unpaired new position, update for a changed paired one.
      S_NEW: begin
        if (i_r == new_fill_r) begin
          state_nxt = S_END;
        end else if (!new_paired_r[i_idx]) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = K_INSERT;
            out_oi_nxt    = '0;
            out_ni_nxt    = i_idx;
            out_ovf_nxt   = 1'b0;
            out_last_nxt  = 1'b0;
            ins_nxt       = ins_r + 1'b1;
            i_nxt         = i_r + 1'b1;
          end
        end else if (!chg_r[i_idx]) begin
          state_nxt = S_MOVE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_UPDATE;
          out_oi_nxt    = p_idx;
          out_ni_nxt    = '0;
          out_ovf_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          state_nxt     = S_MOVE;
        end
      end
      // Move when the shifted old position misses the new one.
      S_MOVE: begin
        if (move_pos == {2'b00, i_idx}) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_NEW;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_MOVE;
          out_oi_nxt    = p_idx;
          out_ni_nxt    = i_idx;
          out_ovf_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          i_nxt         = i_r + 1'b1;
          state_nxt     = S_NEW;
        end
      end
      // Closing word, then both lists are emptied.
      S_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_END;
          out_oi_nxt    = '0;
          out_ni_nxt    = '0;
          out_ovf_nxt   = dropped_r;
          out_last_nxt  = 1'b1;
          old_fill_nxt  = '0;
          new_fill_nxt  = '0;
          dropped_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_fill_r  <= '0;
      new_fill_r  <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      old_fill_r  <= old_fill_nxt;
      new_fill_r  <= new_fill_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    o_r          <= o_nxt;
    k_r          <= k_nxt;
    del_r        <= del_nxt;
    ins_r        <= ins_nxt;
    key_a_r      <= key_a_nxt;
    old_paired_r <= old_paired_nxt;
    new_paired_r <= new_paired_nxt;
    diff_r       <= diff_nxt;
    chg_r        <= chg_nxt;
    part_r       <= part_nxt;
    doff_r       <= doff_nxt;
    out_kind_r   <= out_kind_nxt;
    out_oi_r     <= out_oi_nxt;
    out_ni_r     <= out_ni_nxt;
    out_ovf_r    <= out_ovf_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_old_index = out_oi_r;
  assign out_new_index = out_ni_r;
  assign out_overflow  = out_ovf_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

@@ hdl/list_diff_engine.sv @@
// Top level of the list diff engine: list store and diff sequencer.
//
//   Channel  Role    Word carries
//   in_ch    sink    op, item_key, contents_key
//   out_ch   source  kind, old_index, new_index, overflow, last
//
// A compute word starts pairing, then marking, then emitting, all through the one
// 64-bit comparator and the store's single read port per key array. The input is
// not ready from a compute word until its end word is registered.
// Output stalls hold the sequencer; a registered word waits for its taker.
// Reset is synchronous and active low; it empties both lists.
`timescale 1ns / 1ps
`default_nettype none
module list_diff_engine (
  input  wire          clk,
  input  wire          rst_n,
  ldiff_in_if.sink     in_ch,
  ldiff_out_if.source  out_ch
);
  import ldiff_pkg::*;

  wr_t         wr;
  rd_t         rd;
  logic [63:0] nid_q, nc_q, oid_q, oc_q;

  ldiff_store u_store (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .nid_q (nid_q),
    .nc_q  (nc_q),
    .oid_q (oid_q),
    .oc_q  (oc_q)
  );

  ldiff_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_op           (in_ch.op),
    .in_item_key     (in_ch.item_key),
    .in_contents_key (in_ch.contents_key),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_kind        (out_ch.kind),
    .out_old_index   (out_ch.old_index),
    .out_new_index   (out_ch.new_index),
    .out_overflow    (out_ch.overflow),
    .out_last        (out_ch.last),
    .wr              (wr),
    .rd              (rd),
    .nid_q           (nid_q),
    .nc_q            (nc_q),
    .oid_q           (oid_q),
    .oc_q            (oc_q)
  );

endmodule
`default_nettype wire

@@ hdl/ldiff_chk.sv @@
// Port checker of the list diff engine and its binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "list_diff_engine_defines.svh"
module ldiff_chk (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire [1:0] in_op,
  input wire       out_valid,
  input wire       out_ready,
  input wire [2:0] out_kind,
  input wire       out_overflow,
  input wire       out_last
);
  import ldiff_pkg::*;

  // A stalled word stays offered.
  `LDE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // Only the end word is marked last.
  `LDE_ASSERT_IMP(a_last_end, clk, rst_n, out_valid && out_last, out_kind == K_END)
  // Other words carry neither last nor overflow.
  `LDE_ASSERT_IMP(a_plain_word, clk, rst_n, out_valid && (out_kind != K_END), !out_last && !out_overflow)
  // A compute word makes the input busy in the next cycle.
  `LDE_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready && (in_op == OP_COMPUTE), !in_ready)

endmodule

bind list_diff_engine ldiff_chk u_ldiff_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_op        (in_ch.op),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.kind),
  .out_overflow (out_ch.overflow),
  .out_last     (out_ch.last)
);
`default_nettype wire
